// ===== rtl/normalizing_integer_divider_macros.svh =====
// Assertion macros for the normalizing integer divider.
// Included by the modules that carry assertions; needs nothing else.
`ifndef NORMALIZING_INTEGER_DIVIDER_MACROS_SVH
`define NORMALIZING_INTEGER_DIVIDER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define NID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nid_pkg.sv =====
// Package for the normalizing integer divider: word width, payload structs
// and the shared leading-digit encoder. Depends on nothing.
package nid_pkg;

   localparam int WORD_BITS = 32;
   localparam int POS_BITS  = $clog2(WORD_BITS + 2);

   typedef struct packed {
      logic signed [WORD_BITS-1:0] dividend;
      logic [WORD_BITS-2:0]        divisor;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] quotient;
      logic [WORD_BITS-2:0]        remainder;
      logic                        divide_by_zero;
   } rsp_type;

   // 1-based position of the highest set bit, 0 when none.
   function automatic logic [POS_BITS-1:0] lead_pos(input logic [WORD_BITS:0] v);
      logic [POS_BITS-1:0] pos;
      pos = '0;
      for (int i = 0; i <= WORD_BITS; i++) begin
         if (v[i]) begin
            pos = POS_BITS'(i + 1);
         end
      end
      return pos;
   endfunction

endpackage

// ===== rtl/normalizing_integer_divider.sv =====
// Normalizing integer divider: floor quotient and nonnegative remainder.
// One module around a shared add/subtract unit; uses nid_pkg and the
// assertion macros header.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries a
// signed dividend and an unsigned divisor. The result channel (rsp_valid,
// rsp_stall, rsp_data) returns quotient, remainder and divide_by_zero.
// A transfer happens on a rising edge with valid high and stall low.
// req_stall is high while a division runs; one division at a time.
// Steps: after the request transfer the divider encodes the divisor (S_PX),
// then runs shift-and-add steps, each a pass through the leading-digit
// encoder (S_LEAD) and a pass through the adder (S_STEP), then final
// corrections (S_FIX); a zero divisor goes straight to S_OUT, which hands
// the result on. The next request is taken once the divider is back in idle.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls and the next result is ready, the divider
// holds in its output state until the register frees up.
// Reset (synchronous, active high) returns to idle and drops rsp_valid.
module normalizing_integer_divider
   import nid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "normalizing_integer_divider_macros.svh"

   typedef enum logic [2:0] {
      S_IDLE,
      S_PX,
      S_LEAD,
      S_STEP,
      S_FIX,
      S_OUT
   } state_type;

   state_type                state_ff, state_in;
   logic signed [WORD_BITS:0] y_ff, y_in;
   logic [WORD_BITS-1:0]     z_ff, z_in;
   logic [WORD_BITS-2:0]     x_ff, x_in;
   logic [POS_BITS-1:0]      px_ff, px_in;
   logic [POS_BITS-1:0]      d_ff, d_in;
   logic                     dz_ff, dz_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     req_xfer;
   logic                     out_free;
   logic                     y_neg;
   logic [WORD_BITS:0]       enc_in;
   logic [POS_BITS-1:0]      enc_out;
   logic [POS_BITS-1:0]      shamt;
   logic [WORD_BITS:0]       opnd;
   logic signed [WORD_BITS:0] sum;
   logic [WORD_BITS-1:0]     qstep;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign y_neg     = y_ff[WORD_BITS];

   // shared leading-digit encoder: divisor once, then partial remainder
   assign enc_in  = (state_ff == S_PX) ? {2'b00, x_ff} : (y_neg ? ~y_ff : y_ff);
   assign enc_out = lead_pos(enc_in);

   // shared add/subtract unit
   assign shamt = (state_ff == S_STEP) ? d_ff : '0;
   assign opnd  = {2'b00, x_ff} << shamt;
   assign sum   = y_neg ? (y_ff + $signed(opnd)) : (y_ff - $signed(opnd));
   assign qstep = WORD_BITS'(1) << shamt;

   always_comb begin
      state_in     = state_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      x_in         = x_ff;
      px_in        = px_ff;
      d_in         = d_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               y_in     = {req_data.dividend[WORD_BITS-1], req_data.dividend};
               x_in     = req_data.divisor;
               z_in     = '0;
               dz_in    = (req_data.divisor == '0);
               state_in = (req_data.divisor == '0) ? S_OUT : S_PX;
            end
         end
         S_PX: begin
            px_in    = enc_out;
            state_in = S_LEAD;
         end
         S_LEAD: begin
            if (enc_out > px_ff) begin
               d_in     = enc_out - px_ff;
               state_in = S_STEP;
            end else begin
               state_in = S_FIX;
            end
         end
         S_STEP: begin
            y_in     = sum;
            z_in     = y_neg ? (z_ff - qstep) : (z_ff + qstep);
            state_in = S_LEAD;
         end
         S_FIX: begin
            if (y_neg) begin
               y_in = sum;
               z_in = z_ff - qstep;
            end else if (!sum[WORD_BITS]) begin
               y_in = sum;
               z_in = z_ff + qstep;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (dz_ff) begin
                  rsp_data_in = '{quotient: '0, remainder: '0, divide_by_zero: 1'b1};
               end else begin
                  rsp_data_in = '{quotient: z_ff, remainder: y_ff[WORD_BITS-2:0],
                                  divide_by_zero: 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      y_ff         <= y_in;
      z_ff         <= z_in;
      x_ff         <= x_in;
      px_ff        <= px_in;
      d_ff         <= d_in;
      dz_ff        <= dz_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NID_ASSERT_SAME(a_step_nonzero, clock, reset, state_ff == S_STEP, d_ff != '0, "zero shift step")
   `NID_ASSERT_SAME(a_rem_in_range, clock, reset, (state_ff == S_OUT) && !dz_ff, (!y_ff[WORD_BITS]) && (y_ff < $signed({2'b00, x_ff})), "remainder out of range")
   `NID_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_OUT, "result without output state")
   `NID_ASSERT_NEXT(a_accept_path, clock, reset, req_xfer, (state_ff == S_PX) || (state_ff == S_OUT), "bad state after transfer")

endmodule
